@@ rtl/bpa_pkg.sv @@
// Shared constants, command and status types, and helper functions of the buddy allocator.
package bpa_pkg;

    localparam int NUM_PAGES  = 16384;
    localparam int NUM_ORDERS = 11;
    localparam int PAGE_W     = 14;
    localparam int LINK_W     = 15;
    localparam int ORD_W      = 4;
    localparam int CNT_W      = 15;
    localparam int OP_W       = 5;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_PAGES);

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [OP_W-1:0] OP_NONE       = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD       = 5'd1;
    localparam logic [OP_W-1:0] OP_CLEAR      = 5'd2;
    localparam logic [OP_W-1:0] OP_ADD_ORDER  = 5'd3;
    localparam logic [OP_W-1:0] OP_WRMARK     = 5'd4;
    localparam logic [OP_W-1:0] OP_PUSHT1     = 5'd5;
    localparam logic [OP_W-1:0] OP_PUSHT2     = 5'd6;
    localparam logic [OP_W-1:0] OP_PUSHH1     = 5'd7;
    localparam logic [OP_W-1:0] OP_PUSHH2     = 5'd8;
    localparam logic [OP_W-1:0] OP_ADD_ADV    = 5'd9;
    localparam logic [OP_W-1:0] OP_RDLINK     = 5'd10;
    localparam logic [OP_W-1:0] OP_UNLINK     = 5'd11;
    localparam logic [OP_W-1:0] OP_SRCH_INC   = 5'd12;
    localparam logic [OP_W-1:0] OP_SETP       = 5'd13;
    localparam logic [OP_W-1:0] OP_SPLIT      = 5'd14;
    localparam logic [OP_W-1:0] OP_ALLOC_FIN  = 5'd15;
    localparam logic [OP_W-1:0] OP_RDMARK     = 5'd16;
    localparam logic [OP_W-1:0] OP_SETA_IDX   = 5'd17;
    localparam logic [OP_W-1:0] OP_SETA_BUDDY = 5'd18;
    localparam logic [OP_W-1:0] OP_MERGE      = 5'd19;
    localparam logic [OP_W-1:0] OP_RES_ERR    = 5'd20;
    localparam logic [OP_W-1:0] OP_RES_NOSPC  = 5'd21;
    localparam logic [OP_W-1:0] OP_RES_ADD    = 5'd22;
    localparam logic [OP_W-1:0] OP_RES_FREE   = 5'd23;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       cnt_zero;
        logic       range_ok;
        logic       left_zero;
        logic       want_ok;
        logic       o_lt;
        logic       head_null;
        logic       a_lt_n;
        logic       o_gt_want;
        logic       free_pre_ok;
        logic       mark_rd;
        logic       buddy_match;
        logic       o_below_top;
        logic       clear_done;
        logic       out_free;
    } stat_t;

    function automatic logic [ORD_W-1:0] ceil_log2(input logic [CNT_W-1:0] n);
        logic [ORD_W-1:0] r;
        r = '0;
        for (int k = 0; k < CNT_W; k++) begin
            if ((CNT_W+1)'(1) << k < {1'b0, n}) r = r + ORD_W'(1);
        end
        return r;
    endfunction

    function automatic logic [ORD_W-1:0] add_order(input logic [LINK_W-1:0] idx,
                                                   input logic [CNT_W-1:0] left);
        logic [ORD_W-1:0] fl;
        logic [ORD_W-1:0] tz;
        fl = '0;
        tz = '0;
        for (int k = 1; k < NUM_ORDERS; k++) begin
            if ((CNT_W+1)'(1) << k <= {1'b0, left}) fl = fl + ORD_W'(1);
            if ((idx & ((LINK_W'(1) << k) - LINK_W'(1))) == '0) tz = tz + ORD_W'(1);
        end
        return (fl < tz) ? fl : tz;
    endfunction

endpackage

@@ rtl/bpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/bpa_dp.sv @@
// Datapath: page stores, per-order list heads and tails, free total and result register.
module bpa_dp
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             st,
    input  logic [1:0]        req_type,
    input  logic [PAGE_W-1:0] page_index,
    input  logic [CNT_W-1:0]  page_count,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [PAGE_W-1:0] block_index,
    output logic [ORD_W-1:0]  block_order,
    output logic [CNT_W-1:0]  free_page_total
);

    logic [1:0]        req_reg, req_next;
    logic [LINK_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [ORD_W-1:0]  want_reg, want_next;
    logic [ORD_W-1:0]  o_reg, o_next;
    logic [PAGE_W-1:0] p_reg, p_next;
    logic [LINK_W-1:0] a_reg, a_next;
    logic [LINK_W-1:0] lk_reg, lk_next;
    logic [LINK_W-1:0] head_reg [NUM_ORDERS];
    logic [LINK_W-1:0] head_next [NUM_ORDERS];
    logic [LINK_W-1:0] tail_reg [NUM_ORDERS];
    logic [LINK_W-1:0] tail_next [NUM_ORDERS];
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [LINK_W-1:0] clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [PAGE_W-1:0] bidx_reg, bidx_next;
    logic [ORD_W-1:0]  bord_reg, bord_next;
    logic [CNT_W-1:0]  tot_reg, tot_next;

    logic              o_lt;
    logic [LINK_W-1:0] head_o;
    logic [LINK_W-1:0] tail_o;
    logic [CNT_W-1:0]  pow;
    logic [ORD_W-1:0]  o_dec;

    logic              mark_we, mark_wd, mark_rd;
    logic [PAGE_W-1:0] mark_wa;
    logic              ord_we;
    logic [ORD_W-1:0]  ord_wd, ord_rd;
    logic [PAGE_W-1:0] ord_wa;
    logic              next_we;
    logic [LINK_W-1:0] next_wd, next_rd;
    logic [PAGE_W-1:0] next_wa;
    logic              prev_we;
    logic [LINK_W-1:0] prev_wd, prev_rd;
    logic [PAGE_W-1:0] prev_wa;
    logic              mark_re, link_re;

    assign o_lt   = o_reg < ORD_W'(NUM_ORDERS);
    assign head_o = o_lt ? head_reg[o_reg] : NULL_LINK;
    assign tail_o = o_lt ? tail_reg[o_reg] : NULL_LINK;
    assign pow    = CNT_W'(1) << o_reg;
    assign o_dec  = o_reg - ORD_W'(1);

    assign mark_re = (cmd.op == OP_RDMARK);
    assign link_re = (cmd.op == OP_RDLINK);

    always_comb
    begin
        req_next       = req_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        left_next      = left_reg;
        want_next      = want_reg;
        o_next         = o_reg;
        p_next         = p_reg;
        a_next         = a_reg;
        lk_next        = lk_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        total_next     = total_reg;
        clr_next       = clr_reg;
        status_next    = status_reg;
        bidx_next      = bidx_reg;
        bord_next      = bord_reg;
        tot_next       = tot_reg;
        out_valid_next = out_valid_reg && out_stall;
        mark_we = 1'b0;
        mark_wd = 1'b0;
        mark_wa = a_reg[PAGE_W-1:0];
        ord_we  = 1'b0;
        ord_wd  = o_reg;
        ord_wa  = a_reg[PAGE_W-1:0];
        next_we = 1'b0;
        next_wd = NULL_LINK;
        next_wa = a_reg[PAGE_W-1:0];
        prev_we = 1'b0;
        prev_wd = NULL_LINK;
        prev_wa = a_reg[PAGE_W-1:0];

        unique case (cmd.op)
            OP_LOAD:
            begin
                req_next  = req_type;
                idx_next  = {1'b0, page_index};
                cnt_next  = page_count;
                left_next = page_count;
                want_next = ceil_log2(page_count);
                o_next    = ceil_log2(page_count);
            end
            OP_CLEAR:
            begin
                mark_we  = 1'b1;
                mark_wd  = 1'b0;
                mark_wa  = clr_reg[PAGE_W-1:0];
                clr_next = clr_reg + LINK_W'(1);
            end
            OP_ADD_ORDER:
            begin
                o_next = add_order(idx_reg, left_reg);
                a_next = idx_reg;
            end
            OP_WRMARK:
            begin
                mark_we = 1'b1;
                mark_wd = 1'b1;
                ord_we  = 1'b1;
            end
            OP_PUSHT1:
            begin
                lk_next = tail_o;
                prev_we = 1'b1;
                prev_wd = tail_o;
                next_we = 1'b1;
                next_wd = NULL_LINK;
                if (tail_o >= NULL_LINK)
                begin
                    head_next[o_reg] = a_reg;
                end
                tail_next[o_reg] = a_reg;
                total_next = total_reg + pow;
            end
            OP_PUSHT2:
            begin
                next_we = lk_reg < NULL_LINK;
                next_wa = lk_reg[PAGE_W-1:0];
                next_wd = a_reg;
            end
            OP_PUSHH1:
            begin
                lk_next = head_o;
                next_we = 1'b1;
                next_wd = head_o;
                prev_we = 1'b1;
                prev_wd = NULL_LINK;
                if (head_o >= NULL_LINK)
                begin
                    tail_next[o_reg] = a_reg;
                end
                head_next[o_reg] = a_reg;
                total_next = total_reg + pow;
            end
            OP_PUSHH2:
            begin
                prev_we = lk_reg < NULL_LINK;
                prev_wa = lk_reg[PAGE_W-1:0];
                prev_wd = a_reg;
            end
            OP_ADD_ADV:
            begin
                idx_next  = idx_reg + LINK_W'(pow);
                left_next = left_reg - pow;
            end
            OP_UNLINK:
            begin
                if (prev_rd < NULL_LINK)
                begin
                    next_we = 1'b1;
                    next_wa = prev_rd[PAGE_W-1:0];
                    next_wd = next_rd;
                end
                else
                begin
                    head_next[o_reg] = next_rd;
                end
                if (next_rd < NULL_LINK)
                begin
                    prev_we = 1'b1;
                    prev_wa = next_rd[PAGE_W-1:0];
                    prev_wd = prev_rd;
                end
                else
                begin
                    tail_next[o_reg] = prev_rd;
                end
                total_next = total_reg - pow;
            end
            OP_SRCH_INC:
            begin
                o_next = o_reg + ORD_W'(1);
            end
            OP_SETP:
            begin
                p_next = head_o[PAGE_W-1:0];
                a_next = head_o;
            end
            OP_SPLIT:
            begin
                o_next = o_dec;
                a_next = {1'b0, p_reg} + (LINK_W'(1) << o_dec);
            end
            OP_ALLOC_FIN:
            begin
                mark_we        = 1'b1;
                mark_wd        = 1'b0;
                mark_wa        = p_reg;
                ord_we         = 1'b1;
                ord_wd         = want_reg;
                ord_wa         = p_reg;
                out_valid_next = 1'b1;
                status_next    = ST_OK;
                bidx_next      = p_reg;
                bord_next      = want_reg;
                tot_next       = total_reg;
            end
            OP_SETA_IDX:
            begin
                a_next = idx_reg;
            end
            OP_SETA_BUDDY:
            begin
                a_next = idx_reg ^ (LINK_W'(1) << o_reg);
            end
            OP_MERGE:
            begin
                mark_we = 1'b1;
                mark_wd = 1'b0;
                if (a_reg < idx_reg)
                begin
                    idx_next = a_reg;
                end
                o_next = o_reg + ORD_W'(1);
            end
            OP_RES_ERR, OP_RES_NOSPC, OP_RES_ADD, OP_RES_FREE:
            begin
                out_valid_next = 1'b1;
                status_next    = (cmd.op == OP_RES_ERR)   ? ST_INVALID :
                                 (cmd.op == OP_RES_NOSPC) ? ST_NOSPACE : ST_OK;
                bidx_next      = '0;
                bord_next      = (cmd.op == OP_RES_FREE) ? o_reg : '0;
                tot_next       = total_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_ORDERS; k++)
            begin
                head_reg[k] <= NULL_LINK;
                tail_reg[k] <= NULL_LINK;
            end
            total_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            total_reg     <= total_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        left_reg   <= left_next;
        want_reg   <= want_next;
        o_reg      <= o_next;
        p_reg      <= p_next;
        a_reg      <= a_next;
        lk_reg     <= lk_next;
        status_reg <= status_next;
        bidx_reg   <= bidx_next;
        bord_reg   <= bord_next;
        tot_reg    <= tot_next;
    end

    bpa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_mark (
        .clk(clk), .we(mark_we), .waddr(mark_wa), .wdata(mark_wd),
        .re(mark_re), .raddr(a_reg[PAGE_W-1:0]), .rdata(mark_rd)
    );

    bpa_ram #(.WIDTH(ORD_W), .DEPTH(NUM_PAGES)) u_ord (
        .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd),
        .re(mark_re), .raddr(a_reg[PAGE_W-1:0]), .rdata(ord_rd)
    );

    bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_next (
        .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
        .re(link_re), .raddr(a_reg[PAGE_W-1:0]), .rdata(next_rd)
    );

    bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_prev (
        .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
        .re(link_re), .raddr(a_reg[PAGE_W-1:0]), .rdata(prev_rd)
    );

    always_comb
    begin
        st.req         = req_reg;
        st.cnt_zero    = cnt_reg == '0;
        st.range_ok    = ({1'b0, idx_reg} + {1'b0, cnt_reg}) <= (LINK_W+1)'(NUM_PAGES);
        st.left_zero   = left_reg == '0;
        st.want_ok     = want_reg < ORD_W'(NUM_ORDERS);
        st.o_lt        = o_lt;
        st.head_null   = head_o >= NULL_LINK;
        st.a_lt_n      = a_reg < NULL_LINK;
        st.o_gt_want   = o_reg > want_reg;
        st.free_pre_ok = o_lt && ((idx_reg & (LINK_W'(pow) - LINK_W'(1))) == '0) &&
                         (({1'b0, idx_reg} + (LINK_W+1)'(pow)) <= (LINK_W+1)'(NUM_PAGES));
        st.mark_rd     = mark_rd;
        st.buddy_match = mark_rd && (ord_rd == o_reg);
        st.o_below_top = o_reg < ORD_W'(NUM_ORDERS - 1);
        st.clear_done  = clr_reg == LINK_W'(NUM_PAGES);
        st.out_free    = !out_valid_reg || !out_stall;
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign block_index     = bidx_reg;
    assign block_order     = bord_reg;
    assign free_page_total = tot_reg;

endmodule

@@ rtl/bpa_ctrl.sv @@
// Controller: sequences clear pass, region add, allocate and free over the datapath.
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t st,
    output cmd_t  cmd
);

    localparam logic [4:0] S_CLEAR     = 5'd0;
    localparam logic [4:0] S_IDLE      = 5'd1;
    localparam logic [4:0] S_DECODE    = 5'd2;
    localparam logic [4:0] S_ADD_ORD   = 5'd3;
    localparam logic [4:0] S_ADD_MK    = 5'd4;
    localparam logic [4:0] S_ADD_T1    = 5'd5;
    localparam logic [4:0] S_ADD_T2    = 5'd6;
    localparam logic [4:0] S_ADD_ADV   = 5'd7;
    localparam logic [4:0] S_SRCH      = 5'd8;
    localparam logic [4:0] S_AL_RD     = 5'd9;
    localparam logic [4:0] S_AL_UN     = 5'd10;
    localparam logic [4:0] S_AL_SPL    = 5'd11;
    localparam logic [4:0] S_AL_CHK    = 5'd12;
    localparam logic [4:0] S_AL_H1     = 5'd13;
    localparam logic [4:0] S_AL_H2     = 5'd14;
    localparam logic [4:0] S_AL_FIN    = 5'd15;
    localparam logic [4:0] S_FR_RD     = 5'd16;
    localparam logic [4:0] S_FR_CK     = 5'd17;
    localparam logic [4:0] S_FR_LOOP   = 5'd18;
    localparam logic [4:0] S_FR_BRD    = 5'd19;
    localparam logic [4:0] S_FR_BCK    = 5'd20;
    localparam logic [4:0] S_FR_UN     = 5'd21;
    localparam logic [4:0] S_FR_MG     = 5'd22;
    localparam logic [4:0] S_FR_DONE   = 5'd23;
    localparam logic [4:0] S_FR_MK     = 5'd24;
    localparam logic [4:0] S_FR_H1     = 5'd25;
    localparam logic [4:0] S_FR_H2     = 5'd26;
    localparam logic [4:0] S_FIN_FREE  = 5'd27;
    localparam logic [4:0] S_FIN_ERR   = 5'd28;
    localparam logic [4:0] S_FIN_NOSPC = 5'd29;
    localparam logic [4:0] S_FIN_ADD   = 5'd30;

    logic [4:0] state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (st.clear_done) state_next = S_IDLE;
                else cmd.op = OP_CLEAR;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (st.cnt_zero) state_next = S_FIN_ERR;
                else if (st.req == REQ_ADD)
                    state_next = st.range_ok ? S_ADD_ORD : S_FIN_ERR;
                else if (st.req == REQ_ALLOC)
                    state_next = st.want_ok ? S_SRCH : S_FIN_NOSPC;
                else if (st.req == REQ_FREE)
                begin
                    if (st.free_pre_ok)
                    begin
                        cmd.op     = OP_SETA_IDX;
                        state_next = S_FR_RD;
                    end
                    else state_next = S_FIN_ERR;
                end
                else state_next = S_FIN_ERR;
            end
            S_ADD_ORD:
            begin
                if (st.left_zero) state_next = S_FIN_ADD;
                else
                begin
                    cmd.op     = OP_ADD_ORDER;
                    state_next = S_ADD_MK;
                end
            end
            S_ADD_MK:  begin cmd.op = OP_WRMARK;  state_next = S_ADD_T1;  end
            S_ADD_T1:  begin cmd.op = OP_PUSHT1;  state_next = S_ADD_T2;  end
            S_ADD_T2:  begin cmd.op = OP_PUSHT2;  state_next = S_ADD_ADV; end
            S_ADD_ADV: begin cmd.op = OP_ADD_ADV; state_next = S_ADD_ORD; end
            S_SRCH:
            begin
                priority if (!st.o_lt) state_next = S_FIN_NOSPC;
                else if (st.head_null) cmd.op = OP_SRCH_INC;
                else
                begin
                    cmd.op     = OP_SETP;
                    state_next = S_AL_RD;
                end
            end
            S_AL_RD: begin cmd.op = OP_RDLINK; state_next = S_AL_UN;  end
            S_AL_UN: begin cmd.op = OP_UNLINK; state_next = S_AL_SPL; end
            S_AL_SPL:
            begin
                if (st.o_gt_want)
                begin
                    cmd.op     = OP_SPLIT;
                    state_next = S_AL_CHK;
                end
                else state_next = S_AL_FIN;
            end
            S_AL_CHK:
            begin
                if (st.a_lt_n)
                begin
                    cmd.op     = OP_WRMARK;
                    state_next = S_AL_H1;
                end
                else state_next = S_AL_SPL;
            end
            S_AL_H1: begin cmd.op = OP_PUSHH1; state_next = S_AL_H2;  end
            S_AL_H2: begin cmd.op = OP_PUSHH2; state_next = S_AL_SPL; end
            S_AL_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.op     = OP_ALLOC_FIN;
                    state_next = S_IDLE;
                end
            end
            S_FR_RD: begin cmd.op = OP_RDMARK; state_next = S_FR_CK; end
            S_FR_CK: state_next = st.mark_rd ? S_FIN_ERR : S_FR_LOOP;
            S_FR_LOOP:
            begin
                if (st.o_below_top)
                begin
                    cmd.op     = OP_SETA_BUDDY;
                    state_next = S_FR_BRD;
                end
                else state_next = S_FR_DONE;
            end
            S_FR_BRD:
            begin
                if (st.a_lt_n)
                begin
                    cmd.op     = OP_RDMARK;
                    state_next = S_FR_BCK;
                end
                else state_next = S_FR_DONE;
            end
            S_FR_BCK:
            begin
                if (st.buddy_match)
                begin
                    cmd.op     = OP_RDLINK;
                    state_next = S_FR_UN;
                end
                else state_next = S_FR_DONE;
            end
            S_FR_UN:   begin cmd.op = OP_UNLINK;   state_next = S_FR_MG;   end
            S_FR_MG:   begin cmd.op = OP_MERGE;    state_next = S_FR_LOOP; end
            S_FR_DONE: begin cmd.op = OP_SETA_IDX; state_next = S_FR_MK;   end
            S_FR_MK:   begin cmd.op = OP_WRMARK;   state_next = S_FR_H1;   end
            S_FR_H1:   begin cmd.op = OP_PUSHH1;   state_next = S_FR_H2;   end
            S_FR_H2:   begin cmd.op = OP_PUSHH2;   state_next = S_FIN_FREE; end
            S_FIN_FREE, S_FIN_ERR, S_FIN_NOSPC, S_FIN_ADD:
            begin
                if (st.out_free)
                begin
                    cmd.op = (state_reg == S_FIN_FREE)  ? OP_RES_FREE  :
                             (state_reg == S_FIN_ERR)   ? OP_RES_ERR   :
                             (state_reg == S_FIN_NOSPC) ? OP_RES_NOSPC : OP_RES_ADD;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_decode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_LOAD |=> state_reg == S_DECODE)
        else $error("load not followed by decode");

    a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_RES_ERR || cmd.op == OP_RES_NOSPC || cmd.op == OP_RES_ADD ||
         cmd.op == OP_RES_FREE || cmd.op == OP_ALLOC_FIN) |-> st.out_free)
        else $error("result written while output slot busy");

    a_split_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_SPLIT |-> st.o_gt_want)
        else $error("split below requested order");

    a_unlink_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_UNLINK |-> $past(cmd.op) == OP_RDLINK)
        else $error("unlink without link read");

endmodule

@@ rtl/buddy_page_allocator.sv @@
// Top level of the buddy page allocator: controller plus datapath.
// Sequence: add carves the region into aligned blocks one by one; allocate searches the order
// lists upward and then splits; free merges with free buddies; each also decodes and sets a result.
// Throughput: one transaction at a time; the controller accepts again once the result is set.
// Reset: a clearing pass zeroes the free marks, then the controller goes idle;
// input stalls meanwhile. Lists reset empty and the free total to zero.
module buddy_page_allocator
    import bpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        req_type,
    input  logic [PAGE_W-1:0] page_index,
    input  logic [CNT_W-1:0]  page_count,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [PAGE_W-1:0] block_index,
    output logic [ORD_W-1:0]  block_order,
    output logic [CNT_W-1:0]  free_page_total
);

    cmd_t  cmd;
    stat_t st;

    bpa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .st(st), .cmd(cmd)
    );

    bpa_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
        .req_type(req_type), .page_index(page_index), .page_count(page_count),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .block_index(block_index), .block_order(block_order),
        .free_page_total(free_page_total)
    );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the buddy page allocator: directed table, random traffic, predictor.
module tb;
    import bpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]        st;
        logic [PAGE_W-1:0] bi;
        logic [ORD_W-1:0]  bo;
        logic [CNT_W-1:0]  tot;
    } resp_t;

    typedef struct {
        logic [1:0] r;
        int         i;
        int         c;
        bit         typed;
        resp_t      e;
    } row_t;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              in_valid = 0;
    logic              in_stall;
    logic [1:0]        req_type = '0;
    logic [PAGE_W-1:0] page_index = '0;
    logic [CNT_W-1:0]  page_count = '0;
    logic              out_valid;
    logic              out_stall = 0;
    logic [1:0]        status;
    logic [PAGE_W-1:0] block_index;
    logic [ORD_W-1:0]  block_order;
    logic [CNT_W-1:0]  free_page_total;

    buddy_page_allocator DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .page_index(page_index), .page_count(page_count),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .block_index(block_index), .block_order(block_order),
        .free_page_total(free_page_total)
    );

    always #1 clk = ~clk;

    bit   pg_mark [NUM_PAGES];
    int   pg_ord  [NUM_PAGES];
    int   pg_next [NUM_PAGES];
    int   pg_prev [NUM_PAGES];
    int   lst_head [NUM_ORDERS];
    int   lst_tail [NUM_ORDERS];
    int   lst_cnt  [NUM_ORDERS];

    resp_t pending_resp[$];
    int    held_idx[$];
    int    held_ord[$];
    int    errors = 0;
    int    n_sent = 0;
    int    n_recv = 0;
    int    n_ok_alloc = 0;
    int    n_ok_free = 0;
    bit    hold_req = 0;
    bit    sending_done = 0;

    function void list_unlink(int o, int p);
        int nx;
        int pv;
        nx = pg_next[p];
        pv = pg_prev[p];
        if (pv < NUM_PAGES) pg_next[pv] = nx; else lst_head[o] = nx;
        if (nx < NUM_PAGES) pg_prev[nx] = pv; else lst_tail[o] = pv;
        lst_cnt[o] = (lst_cnt[o] - 1) & 'h7fff;
    endfunction

    function void list_push_head(int o, int p);
        int h;
        h = lst_head[o];
        pg_next[p] = h;
        pg_prev[p] = NUM_PAGES;
        if (h < NUM_PAGES) pg_prev[h] = p; else lst_tail[o] = p;
        lst_head[o] = p;
        lst_cnt[o] = (lst_cnt[o] + 1) & 'h7fff;
    endfunction

    function void list_push_tail(int o, int p);
        int t;
        t = lst_tail[o];
        pg_prev[p] = t;
        pg_next[p] = NUM_PAGES;
        if (t < NUM_PAGES) pg_next[t] = p; else lst_head[o] = p;
        lst_tail[o] = p;
        lst_cnt[o] = (lst_cnt[o] + 1) & 'h7fff;
    endfunction

    function int order_of(int n);
        int o;
        o = 0;
        while (o < 31 && (longint'(1) << o) < n) o++;
        return o;
    endfunction

    function resp_t predict_alloc_step(logic [1:0] rq, int idx, int cnt);
        resp_t r;
        longint t;
        int o;
        int want;
        int p;
        int b;
        int left;
        r = '0;
        r.st = ST_INVALID;
        if (cnt == 0 || rq > REQ_FREE) begin
            r.st = ST_INVALID;
        end
        else if (rq == REQ_ADD) begin
            if (idx + cnt <= NUM_PAGES) begin
                left = cnt;
                while (left > 0) begin
                    o = NUM_ORDERS - 1;
                    while (o > 0 && (1 << o) > left) o--;
                    while (o > 0 && (idx & ((1 << o) - 1)) != 0) o--;
                    pg_mark[idx] = 1;
                    pg_ord[idx] = o;
                    list_push_tail(o, idx);
                    idx += 1 << o;
                    left -= 1 << o;
                end
                r.st = ST_OK;
            end
        end
        else if (rq == REQ_ALLOC) begin
            want = order_of(cnt);
            o = want;
            while (o < NUM_ORDERS && lst_head[o] >= NUM_PAGES) o++;
            if (o >= NUM_ORDERS) begin
                r.st = ST_NOSPACE;
            end
            else begin
                p = lst_head[o];
                list_unlink(o, p);
                while (o > want) begin
                    o--;
                    b = p + (1 << o);
                    if (b < NUM_PAGES) begin
                        pg_mark[b] = 1;
                        pg_ord[b] = o;
                        list_push_head(o, b);
                    end
                end
                pg_ord[p] = want;
                pg_mark[p] = 0;
                r.st = ST_OK;
                r.bi = p;
                r.bo = want;
            end
        end
        else begin
            o = order_of(cnt);
            if (o < NUM_ORDERS && (idx & ((1 << o) - 1)) == 0 &&
                idx + (1 << o) <= NUM_PAGES && !pg_mark[idx]) begin
                while (o < NUM_ORDERS - 1) begin
                    b = idx ^ (1 << o);
                    if (b >= NUM_PAGES) break;
                    if (!(pg_mark[b] && pg_ord[b] == o)) break;
                    list_unlink(o, b);
                    pg_mark[b] = 0;
                    if (b < idx) idx = b;
                    o++;
                end
                pg_mark[idx] = 1;
                pg_ord[idx] = o;
                list_push_head(o, idx);
                r.st = ST_OK;
                r.bo = o;
            end
        end
        t = 0;
        for (int k = 0; k < NUM_ORDERS; k++) t += longint'(lst_cnt[k]) << k;
        r.tot = t & 'h7fff;
        return r;
    endfunction

    task automatic send_req(logic [1:0] rq, int idx, int cnt, bit typed, resp_t e);
        resp_t p;
        in_valid   <= 1'b1;
        req_type   <= rq;
        page_index <= idx[PAGE_W-1:0];
        page_count <= cnt[CNT_W-1:0];
        do @(posedge clk); while (in_stall);
        p = predict_alloc_step(rq, idx & 'h3fff, cnt & 'h7fff);
        if (p.st == ST_OK && rq == REQ_ALLOC) begin
            held_idx.push_back(p.bi);
            held_ord.push_back(p.bo);
            n_ok_alloc++;
        end
        if (p.st == ST_OK && rq == REQ_FREE) n_ok_free++;
        pending_resp.push_back(typed ? e : p);
        n_sent++;
    endtask

    task automatic pause_cycles(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    initial begin
        row_t rows[$];
        resp_t z;
        int burst;
        int sel;
        int o;
        int k;
        int c;
        int idx;
        z = '0;
        for (int i = 0; i < NUM_PAGES; i++) begin
            pg_mark[i] = 0; pg_ord[i] = 0; pg_next[i] = 0; pg_prev[i] = 0;
        end
        for (int i = 0; i < NUM_ORDERS; i++) begin
            lst_head[i] = NUM_PAGES; lst_tail[i] = NUM_PAGES; lst_cnt[i] = 0;
        end
        rows.push_back('{REQ_ALLOC, 0, 1, 1, '{ST_NOSPACE, 0, 0, 0}});
        rows.push_back('{REQ_ADD, 5, 0, 1, '{ST_INVALID, 0, 0, 0}});
        rows.push_back('{REQ_ALLOC, 0, 0, 1, '{ST_INVALID, 0, 0, 0}});
        rows.push_back('{REQ_FREE, 0, 0, 1, '{ST_INVALID, 0, 0, 0}});
        rows.push_back('{2'd3, 0, 5, 1, '{ST_INVALID, 0, 0, 0}});
        rows.push_back('{2'd3, 16383, 16384, 1, '{ST_INVALID, 0, 0, 0}});
        rows.push_back('{REQ_ADD, 16383, 2, 1, '{ST_INVALID, 0, 0, 0}});
        rows.push_back('{REQ_ADD, 0, 16384, 1, '{ST_OK, 0, 0, 16384}});
        rows.push_back('{REQ_ALLOC, 0, 16384, 1, '{ST_NOSPACE, 0, 0, 16384}});
        rows.push_back('{REQ_ALLOC, 16383, 1, 1, '{ST_OK, 0, 0, 16383}});
        rows.push_back('{REQ_FREE, 0, 1, 1, '{ST_OK, 0, 10, 16384}});
        rows.push_back('{REQ_FREE, 0, 1, 1, '{ST_INVALID, 0, 0, 16384}});
        rows.push_back('{REQ_FREE, 1, 2, 1, '{ST_INVALID, 0, 0, 16384}});
        rows.push_back('{REQ_FREE, 0, 2000, 1, '{ST_INVALID, 0, 0, 16384}});
        rows.push_back('{REQ_FREE, 16383, 2, 1, '{ST_INVALID, 0, 0, 16384}});
        rows.push_back('{REQ_ALLOC, 0, 1024, 1, '{ST_OK, 0, 10, 15360}});
        rows.push_back('{REQ_ALLOC, 0, 1000, 0, z});
        rows.push_back('{REQ_ALLOC, 0, 3, 0, z});
        rows.push_back('{REQ_ALLOC, 0, 1025, 0, z});
        rows.push_back('{REQ_FREE, 0, 1024, 0, z});
        rows.push_back('{REQ_FREE, 16383, 1, 0, z});
        rows.push_back('{REQ_ADD, 16383, 1, 0, z});
        rows.push_back('{REQ_ALLOC, 0, 1, 0, z});

        rst_n = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i]) send_req(rows[i].r, rows[i].i, rows[i].c, rows[i].typed, rows[i].e);
        pause_cycles(3);

        burst = 0;
        for (int n = 0; n < 1300; n++) begin
            if (n == 300) hold_req = 1;
            if (n == 700) begin
                in_valid <= 1'b0;
                while (pending_resp.size() != 0) @(posedge clk);
            end
            if (n > 900 && n < 1000) burst = 1000;
            if (burst == 0) begin
                pause_cycles($urandom_range(1, 20));
                burst = $urandom_range(1, 30);
            end
            burst--;
            sel = $urandom_range(0, 99);
            if (sel < 42) begin
                o = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 4);
                c = (o == 0) ? 1 : $urandom_range((1 << (o - 1)) + 1, 1 << o);
                send_req(REQ_ALLOC, $urandom_range(0, 16383), c, 0, z);
            end
            else if (sel < 82 && held_idx.size() > 0) begin
                k = $urandom_range(0, held_idx.size() - 1);
                idx = held_idx[k];
                o = held_ord[k];
                held_idx.delete(k);
                held_ord.delete(k);
                c = (o == 0) ? 1 : $urandom_range((1 << (o - 1)) + 1, 1 << o);
                send_req(REQ_FREE, idx, c, 0, z);
            end
            else if (sel < 87) begin
                send_req(REQ_ADD, $urandom_range(0, 16383), $urandom_range(1, 64), 0, z);
            end
            else begin
                send_req($urandom_range(0, 3), $urandom_range(0, 16383),
                         $urandom_range(0, 32767), 0, z);
            end
        end
        in_valid <= 1'b0;
        sending_done = 1;
    end

    task automatic check_field(string nm, int e, int a);
        if (e != a) begin
            $error("%s mismatch: expected %0d, actual %0d", nm, e, a);
            errors++;
        end
    endtask

    initial begin
        int stall_pct;
        int hold_left;
        stall_pct = 0;
        hold_left = 0;
        forever begin
            resp_t e;
            @(posedge clk);
            if (out_valid && !out_stall) begin
                n_recv++;
                if (pending_resp.size() == 0) begin
                    $error("result with no pending transaction");
                    errors++;
                end
                else begin
                    e = pending_resp.pop_front();
                    check_field("status", e.st, status);
                    check_field("block_index", e.bi, block_index);
                    check_field("block_order", e.bo, block_order);
                    check_field("free_page_total", e.tot, free_page_total);
                end
            end
            if (hold_req) begin
                hold_req = 0;
                hold_left = 500;
            end
            if ($urandom_range(0, 63) == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 90;
                endcase
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
            else idle++;
            if (idle >= 60000) begin
                $display("buddy_page_allocator regression: fail");
                $finish;
            end
        end
    end

    initial begin
        wait (sending_done);
        while (pending_resp.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Covered %0d transactions, %0d results: %0d good allocates, %0d good frees.",
                 n_sent, n_recv, n_ok_alloc, n_ok_free);
        $display("Included long output hold-off, drain pause, invalid and overlapping requests.");
        if (errors == 0 && pending_resp.size() == 0) begin
            $display("buddy_page_allocator regression: pass");
        end
        else begin
            $display("buddy_page_allocator regression: fail");
        end
        $finish;
    end
endmodule
